// ----- hw/rtl/mkpc_pkg.sv -----
package mkpc_pkg;

    localparam int NUM_KEYS  = 6;
    localparam int KEY_IDX_W = 3;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CNT_W-1:0] LONG_RST     = 16'd1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESS    = 3'd1,
        PH_HELD     = 3'd2,
        PH_RELEASE  = 3'd3,
        PH_DISABLED = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_LONG_HELD = 2'd1,
        EV_SHORT_UP  = 2'd2,
        EV_LONG_UP   = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        KIND_LONG_HELD = 2'd0,
        KIND_SHORT_UP  = 2'd1,
        KIND_LONG_UP   = 2'd2
    } kind_t;

    // Per-beat control shared by all lanes and the merge stage
    typedef struct packed {
        logic             advance;
        logic             start;
        logic [CNT_W-1:0] debounce;
        logic [CNT_W-1:0] long_press;
    } tick_ctrl_t;

    // Judged result of one beat
    typedef struct packed {
        logic                 report;
        logic                 seen;
        logic [KEY_IDX_W-1:0] key_index;
        kind_t                press_kind;
    } judge_t;

    function automatic kind_t ev_to_kind(input event_t ev);
        kind_t k;
        begin
            k = KIND_LONG_HELD;
            unique case (ev)
                EV_SHORT_UP: k = KIND_SHORT_UP;
                EV_LONG_UP:  k = KIND_LONG_UP;
                default:     k = KIND_LONG_HELD;
            endcase
            return k;
        end
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ----- hw/rtl/mkpc_lane.sv -----
module mkpc_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  mkpc_pkg::tick_ctrl_t ctrl,
    input  logic                released,
    input  logic                clr,
    output mkpc_pkg::event_t    ev_tick
);
    import mkpc_pkg::*;

    phase_t           phase_reg, phase_next, phase_tick;
    event_t           event_reg, event_next, event_tick;
    logic [CNT_W-1:0] press_reg, press_next, press_tick;
    logic [CNT_W-1:0] rel_reg, rel_next, rel_tick;
    logic [CNT_W-1:0] press_inc, rel_inc;

    assign press_inc = sat_inc(press_reg);
    assign rel_inc   = sat_inc(rel_reg);

    // Debounce and hold-time phase machine for one key tick
    always_comb
    begin
        phase_tick = phase_reg;
        event_tick = event_reg;
        press_tick = press_reg;
        rel_tick   = rel_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                event_tick = EV_NONE;
                if (!released)
                begin
                    phase_tick = PH_PRESS;
                    press_tick = '0;
                end
            end
            PH_PRESS:
            begin
                if (!released)
                begin
                    press_tick = press_inc;
                    if (press_inc > ctrl.debounce)
                        phase_tick = PH_HELD;
                end
                else
                begin
                    press_tick = '0;
                    phase_tick = PH_IDLE;
                end
            end
            PH_HELD:
            begin
                press_tick = press_inc;
                if (released)
                begin
                    phase_tick = PH_RELEASE;
                    rel_tick   = '0;
                end
                if (press_inc > ctrl.long_press)
                    event_tick = EV_LONG_HELD;
            end
            PH_RELEASE:
            begin
                press_tick = press_inc;
                if (released)
                begin
                    rel_tick = rel_inc;
                    if (rel_inc > ctrl.debounce)
                    begin
                        event_tick = (event_reg == EV_LONG_HELD) ? EV_LONG_UP : EV_SHORT_UP;
                        press_tick = '0;
                        phase_tick = PH_DISABLED;
                    end
                end
                else
                begin
                    rel_tick   = '0;
                    phase_tick = PH_HELD;
                end
            end
            default: ;
        endcase
    end

    assign ev_tick = event_tick;

    // Apply the tick, the merge-stage rearm, or a start beat
    always_comb
    begin
        phase_next = phase_reg;
        event_next = event_reg;
        press_next = press_reg;
        rel_next   = rel_reg;
        if (ctrl.advance)
        begin
            if (ctrl.start)
                phase_next = PH_IDLE;
            else
            begin
                phase_next = clr ? PH_IDLE : phase_tick;
                event_next = clr ? EV_NONE : event_tick;
                press_next = press_tick;
                rel_next   = rel_tick;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DISABLED;
            event_reg <= EV_NONE;
            press_reg <= '0;
            rel_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            event_reg <= event_next;
            press_reg <= press_next;
            rel_reg   <= rel_next;
        end
    end

endmodule

// ----- hw/rtl/mkpc_merge.sv -----
module mkpc_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  mkpc_pkg::tick_ctrl_t ctrl,
    input  mkpc_pkg::event_t    ev_tick [mkpc_pkg::NUM_KEYS],
    output logic [mkpc_pkg::NUM_KEYS-1:0] clr,
    output mkpc_pkg::judge_t    judge
);
    import mkpc_pkg::*;

    logic latch_reg, latch_next;
    logic latch_walk;

    // Judge keys in index order; the last key with an event wins
    always_comb
    begin
        judge      = '0;
        clr        = '0;
        latch_walk = latch_reg;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (ev_tick[k] != EV_NONE)
            begin
                judge.seen       = 1'b1;
                judge.key_index  = KEY_IDX_W'(k);
                judge.press_kind = ev_to_kind(ev_tick[k]);
                if (ev_tick[k] == EV_LONG_HELD)
                begin
                    if (!latch_walk)
                    begin
                        latch_walk   = 1'b1;
                        judge.report = 1'b1;
                    end
                end
                else
                begin
                    clr[k]       = 1'b1;
                    latch_walk   = 1'b0;
                    judge.report = 1'b1;
                end
            end
        end
    end

    // Hold the shared long-held latch across start beats and cycles with no accepted beat
    assign latch_next = (ctrl.advance && !ctrl.start) ? latch_walk : latch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            latch_reg <= 1'b0;
        else
            latch_reg <= latch_next;
    end

endmodule

// ----- hw/rtl/multi_key_press_classifier_top.sv -----
// Six-key press classifier with debounce and short/long press detection.
// Input stream: one beat per sample tick. s_tdata[5:0] carries the key
// levels (0 = pressed); s_tuser = 1 marks a start beat that arms all keys.
// Output stream: exactly one beat per input beat, in order, carrying the
// report flag, the any-event flag, the winning key index and the press kind.
// Each result is registered: a beat accepted at one edge shows on m_* after it.
// Throughput is one beat per cycle while the receiver does not stall; all key lanes update
// in parallel and the merge stage judges them in the same cycle, so the lane-to-merge-to-lane
// update path sets the figure.
// The output register frees itself when its beat is taken, so s_tready stays
// high while m_tready is high; when the receiver stalls, s_tready drops once
// the output register is full and all state holds.
// Reset: keys are disabled, counters and events cleared, debounce = 20 and
// long press = 1000 ticks. Ticks before a start beat produce zero results.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the edge; the user must
// issue them only while no beat is in flight, as the block itself does not enforce this.
module multi_key_press_classifier_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [5:0] key_levels
    input  logic                          s_tuser,   // [0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] report, [1] event_seen, [4:2] key_index
    output logic [1:0]                    m_tuser,   // [1:0] press_kind
    input  logic                          cfg_we,
    input  logic [mkpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mkpc_pkg::CNT_W-1:0]     cfg_wdata
);
    import mkpc_pkg::*;

    logic [CNT_W-1:0] debounce_reg, debounce_next;
    logic [CNT_W-1:0] long_reg, long_next;
    logic             out_valid_reg, out_valid_next;
    judge_t           out_reg, out_next;

    tick_ctrl_t       ctrl;
    event_t           ev_tick [NUM_KEYS];
    logic [NUM_KEYS-1:0] clr;
    judge_t           judge;
    logic             accept;

    // Configuration writes
    always_comb
    begin
        debounce_next = debounce_reg;
        long_next     = long_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   debounce_next = cfg_wdata;
                CFG_LONG_PRESS: long_next     = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign ctrl.advance    = accept;
    assign ctrl.start      = s_tuser;
    assign ctrl.debounce   = debounce_reg;
    assign ctrl.long_press = long_reg;

    // One lane per key
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        mkpc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .released (s_tdata[k]),
            .clr      (clr[k]),
            .ev_tick  (ev_tick[k])
        );
    end

    mkpc_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .ev_tick (ev_tick),
        .clr     (clr),
        .judge   (judge)
    );

    // Output register: load on accept, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_next       = s_tuser ? '0 : judge;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RST;
            long_reg      <= LONG_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            debounce_reg  <= debounce_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.key_index, out_reg.seen, out_reg.report};
    assign m_tuser  = out_reg.press_kind;

    // A report always comes with an event
    a_report_seen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1] || !m_tdata[0]))
        else $error("report without event");

    // Winning key index stays within the key count
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:2] < KEY_IDX_W'(NUM_KEYS)))
        else $error("key index out of range");

    // A start beat yields an all-zero result in the next cycle
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> (m_tvalid && m_tdata == '0 && m_tuser == '0))
        else $error("start beat result not zero");

    // A rearmed key carries a release event
    a_clr_release: assert property (@(posedge clk) disable iff (!rst_n)
        (clr != '0) |-> judge.report)
        else $error("rearm without report");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mkpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100_000;

    // Beat kinds carried on s_tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Register indexes past the defined list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [NUM_KEYS-1:0] ALL_UP   = 6'h3F;
    localparam logic [NUM_KEYS-1:0] ALL_DOWN = 6'h00;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;     // [5:0] key_levels
    logic                 s_tuser = 1'b0;   // [0] req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [7:0]           m_tdata;          // [0] report, [1] event_seen, [4:2] key_index
    logic [1:0]           m_tuser;          // [1:0] press_kind
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_wdata = '0;

    multi_key_press_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Predicted block state and thresholds
    phase_t           key_ph    [NUM_KEYS];
    logic [CNT_W-1:0] down_ticks[NUM_KEYS];
    logic [CNT_W-1:0] up_ticks  [NUM_KEYS];
    event_t           key_ev    [NUM_KEYS];
    logic             long_latched;
    logic [CNT_W-1:0] debounce_limit;
    logic [CNT_W-1:0] long_limit;

    judge_t pending_verdicts[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int errors             = 0;
    int beats_sent         = 0;
    int results_checked    = 0;
    int reports_seen       = 0;
    int kind_hits[3]       = '{0, 0, 0};
    int unsigned cycle_count = 0;

    // Run-length state of the shaped random key levels
    int   run_left[NUM_KEYS];
    logic key_lvl [NUM_KEYS];

    // Advance every key by one beat and judge them in index order
    function automatic judge_t classify_beat(input logic is_start, input logic [5:0] lv);
        int     k;
        logic   up;
        judge_t v;
        v = '0;
        v.press_kind = KIND_LONG_HELD;
        if (is_start)
        begin
            for (k = 0; k < NUM_KEYS; k++)
                key_ph[k] = PH_IDLE;
            return v;
        end
        for (k = 0; k < NUM_KEYS; k++)
        begin
            up = lv[k];
            case (key_ph[k])
                PH_IDLE:
                begin
                    key_ev[k] = EV_NONE;
                    if (!up)
                    begin
                        key_ph[k]     = PH_PRESS;
                        down_ticks[k] = '0;
                    end
                end
                PH_PRESS:
                begin
                    if (!up)
                    begin
                        if (down_ticks[k] != CNT_MAX)
                            down_ticks[k] = down_ticks[k] + 1'b1;
                        if (down_ticks[k] > debounce_limit)
                            key_ph[k] = PH_HELD;
                    end
                    else
                    begin
                        down_ticks[k] = '0;
                        key_ph[k]     = PH_IDLE;
                    end
                end
                PH_HELD:
                begin
                    if (down_ticks[k] != CNT_MAX)
                        down_ticks[k] = down_ticks[k] + 1'b1;
                    if (up)
                    begin
                        key_ph[k]   = PH_RELEASE;
                        up_ticks[k] = '0;
                    end
                    if (down_ticks[k] > long_limit)
                        key_ev[k] = EV_LONG_HELD;
                end
                PH_RELEASE:
                begin
                    if (down_ticks[k] != CNT_MAX)
                        down_ticks[k] = down_ticks[k] + 1'b1;
                    if (up)
                    begin
                        if (up_ticks[k] != CNT_MAX)
                            up_ticks[k] = up_ticks[k] + 1'b1;
                        if (up_ticks[k] > debounce_limit)
                        begin
                            key_ev[k]     = (key_ev[k] == EV_LONG_HELD) ? EV_LONG_UP
                                                                        : EV_SHORT_UP;
                            down_ticks[k] = '0;
                            key_ph[k]     = PH_DISABLED;
                        end
                    end
                    else
                    begin
                        up_ticks[k] = '0;
                        key_ph[k]   = PH_HELD;
                    end
                end
                default: ;
            endcase
        end
        for (k = 0; k < NUM_KEYS; k++)
        begin
            if (key_ev[k] != EV_NONE)
            begin
                v.seen      = 1'b1;
                v.key_index = KEY_IDX_W'(k);
                case (key_ev[k])
                    EV_SHORT_UP: v.press_kind = KIND_SHORT_UP;
                    EV_LONG_UP:  v.press_kind = KIND_LONG_UP;
                    default:     v.press_kind = KIND_LONG_HELD;
                endcase
                if (key_ev[k] == EV_LONG_HELD)
                begin
                    if (!long_latched)
                    begin
                        long_latched = 1'b1;
                        v.report     = 1'b1;
                    end
                end
                else
                begin
                    key_ev[k]    = EV_NONE;
                    key_ph[k]    = PH_IDLE;
                    long_latched = 1'b0;
                    v.report     = 1'b1;
                end
            end
        end
        return v;
    endfunction

    // Receiver: stall at the configured rate
    always @(negedge clk)
        m_tready <= (receiver_stall_pct == 0) || ($urandom_range(0, 99) >= receiver_stall_pct);

    // Compare each output beat with the oldest prediction
    always @(posedge clk)
    begin : check_result
        judge_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing predicted: tdata=%h tuser=%h",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                results_checked++;
                if (want.report)
                begin
                    reports_seen++;
                    kind_hits[want.press_kind]++;
                end
                if (m_tdata[0] !== want.report)
                begin
                    errors++;
                    $display("%0t: report expected %0b actual %0b", $time, want.report, m_tdata[0]);
                end
                if (m_tdata[1] !== want.seen)
                begin
                    errors++;
                    $display("%0t: event_seen expected %0b actual %0b",
                             $time, want.seen, m_tdata[1]);
                end
                if (m_tdata[4:2] !== want.key_index)
                begin
                    errors++;
                    $display("%0t: key_index expected %0d actual %0d",
                             $time, want.key_index, m_tdata[4:2]);
                end
                if (m_tuser !== want.press_kind)
                begin
                    errors++;
                    $display("%0t: press_kind expected %0d actual %0d",
                             $time, want.press_kind, m_tuser);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_verdicts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Send one beat; entered and left at a falling edge
    task automatic send_beat(input logic req, input logic [5:0] lv);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, lv};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_verdicts.push_back(classify_beat(req, lv));
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic hold_levels(input logic [5:0] lv, input int n);
        repeat (n) send_beat(REQ_TICK, lv);
    endtask

    // Drop valid and wait until every predicted result has left the block
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // Write both thresholds back to back; only call while drained
    task automatic write_thresholds(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] lng);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(negedge clk);
        debounce_limit = deb;
        cfg_index <= CFG_LONG_PRESS;
        cfg_wdata <= lng;
        @(negedge clk);
        long_limit = lng;
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Keys stay disabled until a start beat; thresholds at reset values
    task automatic test_before_start();
        send_beat(REQ_TICK, ALL_DOWN);
        send_beat(REQ_TICK, ALL_UP);
        send_beat(REQ_TICK, 6'h2A);
        send_beat(REQ_TICK, 6'h15);
        wait_drained();
    endtask

    // Writes past the register list must not disturb the thresholds
    task automatic test_spare_index();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_A;
        cfg_wdata <= CNT_W'($urandom);
        @(negedge clk);
        cfg_index <= CFG_SPARE_B;
        cfg_wdata <= CNT_W'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Glitch, short press, long press with release bounce, all keys at once
    task automatic test_press_kinds();
        write_thresholds(16'd1, 16'd3);
        send_beat(REQ_START, ALL_UP);
        hold_levels(6'h3E, 1);
        hold_levels(ALL_UP, 1);
        hold_levels(6'h3E, 3);
        hold_levels(ALL_UP, 3);
        hold_levels(6'h1F, 6);
        hold_levels(ALL_UP, 1);
        hold_levels(6'h1F, 1);
        hold_levels(ALL_UP, 3);
        hold_levels(ALL_DOWN, 6);
        hold_levels(ALL_UP, 3);
        wait_drained();
    endtask

    // Thresholds at zero and at full scale, where the compare never passes
    task automatic test_threshold_extremes();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_thresholds(16'd0, 16'd0);
        send_beat(REQ_START, ALL_UP);
        hold_levels(6'h3E, 3);
        hold_levels(ALL_UP, 3);
        wait_drained();
        write_thresholds(CNT_MAX, CNT_MAX);
        send_beat(REQ_START, ALL_UP);
        hold_levels(6'h3D, 6);
        hold_levels(ALL_UP, 3);
        wait_drained();
        write_thresholds(16'd0, CNT_MAX);
        hold_levels(6'h3D, 2);
        hold_levels(ALL_UP, 3);
        wait_drained();
    endtask

    // Mostly debounced press/release runs per key, some noise and restarts
    task automatic test_random_traffic(input int snd, input int rcv, input int deb,
                                       input int lng, input int n, input bit pause_mid);
        int          i;
        int          k;
        int          r;
        int          hold_span;
        logic [5:0]  lv;
        wait_drained();
        sender_idle_pct    = snd;
        receiver_stall_pct = rcv;
        write_thresholds(CNT_W'(deb), CNT_W'(lng));
        hold_span = (lng > 40) ? 40 : lng;
        for (k = 0; k < NUM_KEYS; k++)
        begin
            run_left[k] = 0;
            key_lvl[k]  = 1'b0;
        end
        send_beat(REQ_START, 6'($urandom));
        for (i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                send_beat(REQ_START, 6'($urandom));
            end
            else if (r < 8)
            begin
                send_beat(REQ_TICK, 6'($urandom));
            end
            else
            begin
                for (k = 0; k < NUM_KEYS; k++)
                begin
                    if (run_left[k] == 0)
                    begin
                        key_lvl[k]  = ~key_lvl[k];
                        run_left[k] = key_lvl[k] ? $urandom_range(1, 3 * deb + 8)
                                                 : $urandom_range(1, deb + hold_span + 4);
                    end
                    run_left[k]--;
                    lv[k] = key_lvl[k];
                end
                send_beat(REQ_TICK, lv);
            end
        end
    endtask

    initial
    begin
        int k;
        debounce_limit = DEBOUNCE_RST;
        long_limit     = LONG_RST;
        long_latched   = 1'b0;
        for (k = 0; k < NUM_KEYS; k++)
        begin
            key_ph[k]     = PH_DISABLED;
            down_ticks[k] = '0;
            up_ticks[k]   = '0;
            key_ev[k]     = EV_NONE;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_before_start();
        test_spare_index();
        test_press_kinds();
        test_threshold_extremes();
        test_random_traffic(0, 0, 2, 8, 130, 1'b0);
        test_random_traffic(62, 0, 0, 0, 130, 1'b0);
        test_random_traffic(0, 62, 3, 12, 130, 1'b1);
        test_random_traffic(13, 13, 1, 65535, 130, 1'b0);

        // Let the last beats drain, then settle
        wait_drained();
        repeat (5) @(negedge clk);

        $display("Sent %0d beats, checked %0d results, %0d reported events",
                 beats_sent, results_checked, reports_seen);
        $display("Reported kinds: long held %0d, short release %0d, long release %0d",
                 kind_hits[KIND_LONG_HELD], kind_hits[KIND_SHORT_UP], kind_hits[KIND_LONG_UP]);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mkpc_pkg.sv
hw/rtl/mkpc_lane.sv
hw/rtl/mkpc_merge.sv
hw/rtl/multi_key_press_classifier_top.sv
tb/tb_top.sv
